// ----- rtl/core/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Item types, operation and target codes, register command codes and the
// decode structures shared by the mapper modules.
// ----------------------------------------------------------------------------
package bsm_pkg;

	// Number of 1 KiB CHR bank slots.
	localparam int CHR_SLOTS_DEF = 8;

	// Operand widths of the shared remainder unit.
	localparam int DVD_W = 13;
	localparam int DVS_W = 14;

	// Operation codes.
	localparam logic [2:0] OP_CPU_RD = 3'd0;
	localparam logic [2:0] OP_CPU_WR = 3'd1;
	localparam logic [2:0] OP_PPU_RD = 3'd2;
	localparam logic [2:0] OP_PPU_WR = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;

	// Target codes.
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_PRG  = 2'd1;
	localparam logic [1:0] TGT_RAM  = 2'd2;
	localparam logic [1:0] TGT_CHR  = 2'd3;

	// Command register codes above the CHR bank slots.
	localparam logic [3:0] CMD_PRG_FIRST = 4'd8;
	localparam logic [3:0] CMD_MIRROR    = 4'd12;
	localparam logic [3:0] CMD_IRQ_CTL   = 4'd13;
	localparam logic [3:0] CMD_CNT_LO    = 4'd14;
	localparam logic [3:0] CMD_CNT_HI    = 4'd15;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAM_BYTES = 2'd1;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd2;

	// Configuration reset values.
	localparam logic [8:0]  PRG_COUNT_RST = 9'd32;
	localparam logic [13:0] RAM_BYTES_RST = 14'd8192;
	localparam logic [8:0]  CHR_COUNT_RST = 9'd256;
	localparam logic [8:0]  COUNT_MAX     = 9'd256;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
	} in_item_t;

	typedef struct packed {
		logic        handled;
		logic [1:0]  target;
		logic [20:0] mem_address;
		logic        mem_write;
		logic [7:0]  mem_wdata;
		logic [1:0]  mirror_mode;
		logic        irq_out;
	} out_item_t;

	// Translation request produced by the decoder.
	typedef struct packed {
		logic             handled;
		logic [1:0]       target;
		logic             need_mod;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [12:0]      low_addr;
		logic             mem_write;
		logic [7:0]       mem_wdata;
	} xlat_t;

	// Register updates produced by the decoder.
	typedef struct packed {
		logic       cmd_we;
		logic       chr_we;
		logic       prg_we;
		logic       mirror_we;
		logic       ctl_we;
		logic       cnt_lo_we;
		logic       cnt_hi_we;
		logic       tick;
		logic [7:0] value;
	} upd_t;

	// Bank fixed at C000 after a count write: count minus two, floored at zero.
	function automatic logic [7:0] last_fixed_bank(input logic [8:0] n);
		logic [8:0] d;
		begin
			d = n - 9'd2;
			last_fixed_bank = (n >= 9'd2) ? d[7:0] : 8'd0;
		end
	endfunction

	// Bank counts above COUNT_MAX (256) saturate to it.
	function automatic logic [8:0] clamp_count(input logic [8:0] n);
		clamp_count = (n > COUNT_MAX) ? COUNT_MAX : n;
	endfunction

endpackage

// ----- rtl/core/bsm_remu.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper remainder unit
// Restoring remainder, one dividend bit per cycle, shared by every bank and
// RAM window reduction.
// ----------------------------------------------------------------------------
module bsm_remu #(
	parameter int DVD_W = bsm_pkg::DVD_W,
	parameter int DVS_W = bsm_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(DVD_W - 1);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
		end
	end

	assign done      = run_q && (cnt_q == '0);
	assign remainder = rem_q;

endmodule

// ----- rtl/core/bsm_decode.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper decoder
// Classifies a bus access against the bank registers and sizes, producing the
// translation request and the register updates it causes.
// ----------------------------------------------------------------------------
module bsm_decode #(
	parameter int CHR_SLOTS = bsm_pkg::CHR_SLOTS_DEF
) (
	input  bsm_pkg::in_item_t item,
	input  logic [8:0]        prg_count,
	input  logic [13:0]       ram_bytes,
	input  logic [8:0]        chr_count,
	input  logic [7:0]        prg_bank [4],
	input  logic [7:0]        chr_bank [CHR_SLOTS],
	input  logic [3:0]        cmd,
	output bsm_pkg::xlat_t    xlat,
	output bsm_pkg::upd_t     upd
);

	import bsm_pkg::*;

	localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

	logic [15:0]          a;
	logic [8:0]           prg_n;
	logic [8:0]           chr_n;
	logic [8:0]           prg_last;
	logic [7:0]           r0;
	logic                 ram_present;
	logic [CHR_IDX_W-1:0] chr_idx;

	assign a           = item.bus_address;
	assign prg_n       = clamp_count(prg_count);
	assign chr_n       = clamp_count(chr_count);
	assign prg_last    = prg_n - 9'd1;
	assign r0          = prg_bank[0];
	assign ram_present = (ram_bytes != '0);
	assign chr_idx     = a[10 +: CHR_IDX_W];

	// Access classification.
	always_comb begin
		xlat = '0;
		upd  = '0;
		upd.value = item.write_data;
		xlat.low_addr = a[12:0];
		case (item.operation)
			OP_CPU_RD: begin
				if (prg_n != '0) begin
					if (a[15:13] == 3'b011) begin
						xlat.handled = 1'b1;
						if (!r0[7]) begin
							xlat.target   = TGT_PRG;
							xlat.need_mod = 1'b1;
							xlat.dividend = DVD_W'(r0[5:0]);
							xlat.divisor  = DVS_W'(prg_n);
						end else if (ram_present) begin
							xlat.target   = TGT_RAM;
							xlat.need_mod = 1'b1;
							xlat.dividend = DVD_W'(a[12:0]);
							xlat.divisor  = ram_bytes;
						end
					end else if (a[15]) begin
						xlat.handled  = 1'b1;
						xlat.target   = TGT_PRG;
						xlat.need_mod = 1'b1;
						xlat.divisor  = DVS_W'(prg_n);
						case (a[14:13])
							2'd0:    xlat.dividend = DVD_W'(prg_bank[1][5:0]);
							2'd1:    xlat.dividend = DVD_W'(prg_bank[2][5:0]);
							2'd2:    xlat.dividend = DVD_W'(prg_bank[3][5:0]);
							default: xlat.dividend = DVD_W'(prg_last[7:0]);
						endcase
					end
				end
			end
			OP_CPU_WR: begin
				if (a[15:13] == 3'b011) begin
					if (r0[7] && r0[6] && ram_present) begin
						xlat.target    = TGT_RAM;
						xlat.need_mod  = 1'b1;
						xlat.dividend  = DVD_W'(a[12:0]);
						xlat.divisor   = ram_bytes;
						xlat.mem_write = 1'b1;
						xlat.mem_wdata = item.write_data;
					end
				end else if (a[15:13] == 3'b100) begin
					upd.cmd_we = 1'b1;
				end else if (a[15:13] == 3'b101) begin
					// Data port: the command register picks the destination.
					if (cmd < CMD_PRG_FIRST) begin
						upd.chr_we = 1'b1;
					end else if (cmd < CMD_MIRROR) begin
						upd.prg_we = 1'b1;
					end else begin
						unique case (cmd)
							CMD_MIRROR:  upd.mirror_we = 1'b1;
							CMD_IRQ_CTL: upd.ctl_we    = 1'b1;
							CMD_CNT_LO:  upd.cnt_lo_we = 1'b1;
							default:     upd.cnt_hi_we = 1'b1;
						endcase
					end
				end
			end
			OP_PPU_RD, OP_PPU_WR: begin
				if ((a[15:13] == 3'b000) && (chr_n != '0)) begin
					xlat.target   = TGT_CHR;
					xlat.need_mod = 1'b1;
					xlat.dividend = DVD_W'(chr_bank[chr_idx]);
					xlat.divisor  = DVS_W'(chr_n);
					if (item.operation == OP_PPU_RD) begin
						xlat.handled = 1'b1;
					end else begin
						xlat.mem_write = 1'b1;
						xlat.mem_wdata = item.write_data;
					end
				end
			end
			OP_TICK: begin
				upd.tick = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/core/bank_switch_mapper_irq.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper with cycle IRQ counter
// Flow: register writes, ticks and unmapped accesses pass from the done state
// into the output register; translated accesses first wait in the reduction
// state for the 13 one-bit steps of the shared remainder unit.
// One item at a time: input stalls until the output register takes the last.
// Reset: asynchronous, clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
module bank_switch_mapper_irq #(
	parameter int CHR_SLOTS = bsm_pkg::CHR_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bsm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bsm_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [13:0]        cfg_data
);

	import bsm_pkg::*;

	localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic             in_xfer;
	logic             out_xfer;
	logic             cfg_xfer;

	logic [8:0]       prg_count_q;
	logic [13:0]      ram_bytes_q;
	logic [8:0]       chr_count_q;
	logic [3:0]       cmd_q;
	logic [7:0]       prg_bank_q [4];
	logic [7:0]       chr_bank_q [CHR_SLOTS];
	logic [1:0]       irq_ctl_q;
	logic [15:0]      counter_q;
	logic [1:0]       mirror_q;
	logic             irq_pending_q;

	xlat_t            xlat;
	upd_t             upd;
	xlat_t            xlat_q;
	logic             mod_done;
	logic [DVS_W-1:0] remainder;
	logic [20:0]      maddr;
	out_item_t        out_q;
	logic             out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	bsm_decode #(
		.CHR_SLOTS (CHR_SLOTS)
	) u_decode (
		.item      (in_data),
		.prg_count (prg_count_q),
		.ram_bytes (ram_bytes_q),
		.chr_count (chr_count_q),
		.prg_bank  (prg_bank_q),
		.chr_bank  (chr_bank_q),
		.cmd       (cmd_q),
		.xlat      (xlat),
		.upd       (upd)
	);

	bsm_remu #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_remu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer && xlat.need_mod),
		.dividend  (xlat.dividend),
		.divisor   (xlat.divisor),
		.done      (mod_done),
		.remainder (remainder)
	);

	// Sequencer: accept, optional reduction, then hand off to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= xlat.need_mod ? ST_MOD : ST_DONE;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The accepted request is held while the remainder unit works.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			xlat_q <= xlat;
		end
	end

	// Mapper registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q   <= PRG_COUNT_RST;
			ram_bytes_q   <= RAM_BYTES_RST;
			chr_count_q   <= CHR_COUNT_RST;
			cmd_q         <= '0;
			prg_bank_q[0] <= 8'd0;
			prg_bank_q[1] <= 8'd0;
			prg_bank_q[2] <= 8'd1;
			prg_bank_q[3] <= last_fixed_bank(PRG_COUNT_RST);
			for (int i = 0; i < CHR_SLOTS; i++) begin
				chr_bank_q[i] <= '0;
			end
			irq_ctl_q     <= '0;
			counter_q     <= '0;
			mirror_q      <= '0;
			irq_pending_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				if (upd.cmd_we) begin
					cmd_q <= upd.value[3:0];
				end
				if (upd.chr_we) begin
					chr_bank_q[cmd_q[CHR_IDX_W-1:0]] <= upd.value;
				end
				if (upd.prg_we) begin
					prg_bank_q[cmd_q[1:0]] <= upd.value;
				end
				if (upd.mirror_we) begin
					mirror_q <= upd.value[1:0];
				end
				if (upd.ctl_we) begin
					irq_ctl_q     <= {upd.value[7], upd.value[0]};
					irq_pending_q <= 1'b0;
				end
				if (upd.cnt_lo_we) begin
					counter_q[7:0] <= upd.value;
				end
				if (upd.cnt_hi_we) begin
					counter_q[15:8] <= upd.value;
				end
				// Counter tick: when counting is enabled, decrement, and raise the IRQ (if enabled) when the count wraps from zero.
				if (upd.tick && irq_ctl_q[1]) begin
					counter_q <= counter_q - 16'd1;
					if ((counter_q == '0) && irq_ctl_q[0]) begin
						irq_pending_q <= 1'b1;
					end
				end
			end
			if (cfg_xfer) begin
				unique case (cfg_index)
					CFG_PRG_COUNT: begin
						prg_count_q   <= cfg_data[8:0];
						prg_bank_q[3] <= last_fixed_bank(cfg_data[8:0]);
					end
					CFG_RAM_BYTES: ram_bytes_q <= cfg_data;
					CFG_CHR_COUNT: chr_count_q <= cfg_data[8:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Physical address from the reduced bank and the window offset, or the reduced RAM offset.
	always_comb begin
		case (xlat_q.target)
			TGT_PRG: maddr = {remainder[7:0], xlat_q.low_addr};
			TGT_RAM: maddr = {8'd0, remainder[12:0]};
			TGT_CHR: maddr = {3'd0, remainder[7:0], xlat_q.low_addr[9:0]};
			default: maddr = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || out_xfer)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_xfer)) begin
			out_q.handled     <= xlat_q.handled;
			out_q.target      <= xlat_q.target;
			out_q.mem_address <= maddr;
			out_q.mem_write   <= xlat_q.mem_write;
			out_q.mem_wdata   <= xlat_q.mem_wdata;
			out_q.mirror_mode <= mirror_q;
			out_q.irq_out     <= irq_pending_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
